[src/twm_pkg.sv]
// Shared constants and types of the thresholded window mean block.
`timescale 1ns / 1ps
`default_nettype none

package twm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_WINDOW  = 256;
	localparam int SCALE       = 65535;

	localparam int CNT_W   = 9;   // 0..MAX_WINDOW
	localparam int SUM_W   = 24;  // window sum plus half the count
	localparam int LIMIT_W = 17;
	localparam int EDGE_W  = 17;
	localparam int PROD_W  = 40;  // mean numerator times reciprocal
	localparam int WIDE_W  = 58;  // widest product and dividend
	localparam int MULT_W  = 18;  // multiplier operand of the shared unit
	localparam int STEP_W  = 6;
	localparam int BLEND_W = 26;
	localparam int KEEP_W  = 18;
	localparam int RES_W   = 28;

	// The scale is 2^FOLD_W - 1, so a division by it folds the upper bits onto the lower.
	localparam int FOLD_W = 16;

	localparam int MUL_STEPS = 18;
	localparam int DIV_STEPS = 5;   // four folds and a final correction

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_DISTANCE_LIMIT = 2'd0;
	localparam logic [1:0] REG_BLEND_STRENGTH = 2'd1;
	localparam logic [1:0] REG_HQ_MODE        = 2'd2;

	localparam logic [LIMIT_W-1:0]     RST_DISTANCE_LIMIT = 17'd40062;
	localparam logic [SAMPLE_BITS-1:0] RST_BLEND_STRENGTH = 16'd65535;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_DIV_SCALE,
		OP_DIV_SCALE_SQ
	} twm_op_t;

	typedef struct packed {
		logic                start;
		twm_op_t             op;
		logic [WIDE_W-1:0]   arg_a;
		logic [MULT_W-1:0]   arg_b;
	} twm_req_t;

endpackage

`default_nettype wire

[src/twm_iter_unit.sv]
// Shared iterative unit: shift-add multiply and division by the fixed scale by folding.
`timescale 1ns / 1ps
`default_nettype none

module twm_iter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  twm_pkg::twm_req_t           req,
	output logic                        done,
	output logic [twm_pkg::WIDE_W-1:0]  result
);
	import twm_pkg::*;

	logic                busy_q;
	logic                done_q;
	twm_op_t             op_q;
	logic [STEP_W-1:0]   step_q;
	logic [WIDE_W-1:0]   acc_q;
	logic [WIDE_W-1:0]   src_q;
	logic [MULT_W-1:0]   mplier_q;

	logic [WIDE_W-1:0]   addend;
	logic [WIDE_W-1:0]   mul_next;
	logic [WIDE_W-1:0]   fold_hi;
	logic [WIDE_W-1:0]   fold_next;
	logic                wrap;
	logic [WIDE_W-1:0]   quot_fin;
	logic                pass_end;

	always_comb begin
		addend    = mplier_q[MULT_W-1] ? src_q : '0;
		mul_next  = {acc_q[WIDE_W-2:0], 1'b0} + addend;
		fold_hi   = src_q >> FOLD_W;
		fold_next = fold_hi + WIDE_W'(src_q[FOLD_W-1:0]);
		wrap      = (src_q == WIDE_W'({FOLD_W{1'b1}}));
		quot_fin  = acc_q + WIDE_W'(wrap);
		pass_end  = (step_q == '0) || (step_q == STEP_W'(DIV_STEPS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					OP_MUL:          step_q <= STEP_W'(MUL_STEPS - 1);
					OP_DIV_SCALE:    step_q <= STEP_W'(DIV_STEPS - 1);
					OP_DIV_SCALE_SQ: step_q <= STEP_W'(2 * DIV_STEPS - 1);
					default:         step_q <= '0;
				endcase
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// The multiplier is consumed from its top bit. A division keeps the running
	// quotient in the accumulator and the folded remainder in the source register;
	// after four folds the remainder is at most the scale itself, which the
	// correction step turns into one more unit of quotient. The square of the
	// scale takes two such passes, the first quotient feeding the second.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			src_q    <= req.arg_a;
			mplier_q <= req.arg_b;
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					acc_q    <= mul_next;
					mplier_q <= {mplier_q[MULT_W-2:0], 1'b0};
				end
				OP_DIV_SCALE, OP_DIV_SCALE_SQ: begin
					if (pass_end) begin
						if (step_q == '0) begin
							acc_q <= quot_fin;
						end else begin
							src_q <= quot_fin;
							acc_q <= '0;
						end
					end else begin
						acc_q <= acc_q + fold_hi;
						src_q <= fold_next;
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

`default_nettype wire

[src/thresholded_window_mean.sv]
// Top level of the thresholded window mean: accumulation, sequencer and register port.
`timescale 1ns / 1ps
`default_nettype none

// Each word carries one window pixel with its centre. A word that does not close
// the window is taken without a stall, so such words may follow back to back.
// The word marked last starts the result sequence, during which pixel_stall is
// high: one shared unit does every multiply by shift and add and every division
// by the scale or by its square. A previous result still held in the output
// register holds the end of the sequence back until it is taken. A finished
// result sits in an output register, so the next window can start while it waits.
module thresholded_window_mean (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [twm_pkg::PADDR_W-1:0]       paddr,
	input  logic [twm_pkg::PDATA_W-1:0]       pwdata,
	output logic [twm_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [twm_pkg::SAMPLE_BITS-1:0]   center_value,
	input  logic [twm_pkg::SAMPLE_BITS-1:0]   neighbour_value,
	input  logic [twm_pkg::EDGE_W-1:0]        edge_pair_sum,
	input  logic                              last_in_window,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [twm_pkg::SAMPLE_BITS-1:0]   smoothed_value,
	output logic [twm_pkg::CNT_W-1:0]         pixels_used
);
	import twm_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MUL_P = 8'b0000_0010,
		ST_DIV_P = 8'b0000_0100,
		ST_MUL_B = 8'b0000_1000,
		ST_DIV_B = 8'b0001_0000,
		ST_MUL_K = 8'b0010_0000,
		ST_DIV_K = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} twm_state_t;

	// Configuration registers
	logic [LIMIT_W-1:0]     distance_limit_q;
	logic [SAMPLE_BITS-1:0] blend_strength_q;
	logic                   hq_mode_q;

	logic cfg_write;
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_limit_q <= RST_DISTANCE_LIMIT;
			blend_strength_q <= RST_BLEND_STRENGTH;
			hq_mode_q        <= 1'b0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_DISTANCE_LIMIT: distance_limit_q <= pwdata[LIMIT_W-1:0];
				REG_BLEND_STRENGTH: blend_strength_q <= pwdata[SAMPLE_BITS-1:0];
				REG_HQ_MODE:        hq_mode_q        <= pwdata[0];
				default:            hq_mode_q        <= hq_mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DISTANCE_LIMIT: prdata = PDATA_W'(distance_limit_q);
			REG_BLEND_STRENGTH: prdata = PDATA_W'(blend_strength_q);
			REG_HQ_MODE:        prdata = PDATA_W'(hq_mode_q);
			default:            prdata = '0;
		endcase
	end

	// Reciprocal table, floor(SCALE / count), entry zero giving a zero mean
	logic [SAMPLE_BITS-1:0] recip_rom [MAX_WINDOW+1];

	for (genvar Idx = 0; Idx <= MAX_WINDOW; Idx++) begin : g_recip
		if (Idx == 0) begin : g_zero
			assign recip_rom[Idx] = '0;
		end else begin : g_entry
			localparam logic [SAMPLE_BITS-1:0] Entry = SAMPLE_BITS'(SCALE / Idx);
			assign recip_rom[Idx] = Entry;
		end
	end

	twm_state_t          state_q;
	logic                issue_q;
	logic                result_valid_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [SUM_W-1:0]       mean_num_q;
	logic [CNT_W-1:0]       used_q;
	logic [SAMPLE_BITS-1:0] centre_q;
	logic [EDGE_W-1:0]      edge_mag_q;
	logic [PROD_W-1:0]      p_q;
	logic [WIDE_W-1:0]      tmp_q;
	logic [BLEND_W-1:0]     blend_q;
	logic [MULT_W-1:0]      str_mag_q;
	logic                   str_neg_q;
	logic [MULT_W-1:0]      wk_q;
	logic [SAMPLE_BITS-1:0] final_q;
	logic [SAMPLE_BITS-1:0] smoothed_q;
	logic [CNT_W-1:0]       pixels_used_q;

	twm_req_t            req;
	logic                unit_done;
	logic [WIDE_W-1:0]   unit_result;

	twm_iter_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (unit_done),
		.result (unit_result)
	);

	// Accumulation of one pixel word
	logic                   accept;
	logic [SAMPLE_BITS-1:0] pix_diff;
	logic                   pix_hit;
	logic [SUM_W-1:0]       sum_next;
	logic [CNT_W-1:0]       cnt_next;
	logic [EDGE_W-1:0]      twice_centre;
	logic [EDGE_W-1:0]      edge_mag;
	logic                   can_load;

	assign pixel_stall = (state_q != ST_IDLE);
	assign accept      = pixel_valid && !pixel_stall;
	assign can_load    = !result_valid_q || !result_stall;

	always_comb begin
		pix_diff = (center_value > neighbour_value) ? center_value - neighbour_value
		                                            : neighbour_value - center_value;
		pix_hit  = ({1'b0, pix_diff} < distance_limit_q) && (cnt_q < CNT_W'(MAX_WINDOW));
		sum_next = pix_hit ? sum_q + SUM_W'(neighbour_value) : sum_q;
		cnt_next = pix_hit ? cnt_q + 1'b1 : cnt_q;
		twice_centre = {center_value, 1'b0};
		edge_mag = (twice_centre >= edge_pair_sum) ? twice_centre - edge_pair_sum
		                                          : edge_pair_sum - twice_centre;
	end

	// Final results of the two modes
	logic [SAMPLE_BITS-1:0] plain_sat;
	logic [KEEP_W-1:0]      keep;
	logic signed [RES_W-1:0] blend_term;
	logic signed [RES_W-1:0] hq_sum;
	logic [SAMPLE_BITS-1:0] hq_sat;

	always_comb begin
		plain_sat = (|unit_result[WIDE_W-1:SAMPLE_BITS]) ? {SAMPLE_BITS{1'b1}}
		                                                 : unit_result[SAMPLE_BITS-1:0];
		keep       = unit_result[KEEP_W-1:0];
		blend_term = signed'(RES_W'(blend_q));
		hq_sum     = str_neg_q ? signed'(RES_W'(keep)) - blend_term
		                       : signed'(RES_W'(keep)) + blend_term;
		if (hq_sum < 0) begin
			hq_sat = '0;
		end else if (hq_sum > signed'(RES_W'(SCALE))) begin
			hq_sat = {SAMPLE_BITS{1'b1}};
		end else begin
			hq_sat = hq_sum[SAMPLE_BITS-1:0];
		end
	end

	always_comb begin
		req = '0;
		case (state_q)
			ST_MUL_P: begin
				req.op    = OP_MUL;
				req.arg_a = WIDE_W'(mean_num_q);
				req.arg_b = MULT_W'(recip_rom[used_q]);
			end
			ST_DIV_P: begin
				req.op    = OP_DIV_SCALE;
				req.arg_a = WIDE_W'(p_q);
			end
			ST_MUL_B: begin
				req.op    = OP_MUL;
				req.arg_a = WIDE_W'(p_q);
				req.arg_b = str_mag_q;
			end
			ST_DIV_B: begin
				req.op    = OP_DIV_SCALE_SQ;
				req.arg_a = tmp_q;
			end
			ST_MUL_K: begin
				req.op    = OP_MUL;
				req.arg_a = WIDE_W'(centre_q);
				req.arg_b = wk_q;
			end
			ST_DIV_K: begin
				req.op    = OP_DIV_SCALE;
				req.arg_a = tmp_q;
			end
			default: begin
				req.op = OP_MUL;
			end
		endcase
		req.start = issue_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			issue_q        <= 1'b0;
			result_valid_q <= 1'b0;
			sum_q          <= '0;
			cnt_q          <= '0;
		end else begin
			issue_q <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last_in_window) begin
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_MUL_P;
							issue_q <= 1'b1;
						end else begin
							sum_q <= sum_next;
							cnt_q <= cnt_next;
						end
					end
				end
				ST_MUL_P: begin
					if (unit_done) begin
						state_q <= hq_mode_q ? ST_MUL_B : ST_DIV_P;
						issue_q <= 1'b1;
					end
				end
				ST_DIV_P, ST_DIV_K: begin
					if (unit_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_MUL_B: begin
					if (unit_done) begin
						state_q <= ST_DIV_B;
						issue_q <= 1'b1;
					end
				end
				ST_DIV_B: begin
					if (unit_done) begin
						state_q <= ST_MUL_K;
						issue_q <= 1'b1;
					end
				end
				ST_MUL_K: begin
					if (unit_done) begin
						state_q <= ST_DIV_K;
						issue_q <= 1'b1;
					end
				end
				ST_FIN: begin
					if (can_load) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand and result registers of the sequence
	always_ff @(posedge clk) begin
		if (accept && last_in_window) begin
			mean_num_q <= sum_next + SUM_W'(cnt_next >> 1);
			used_q     <= cnt_next;
			centre_q   <= center_value;
			edge_mag_q <= edge_mag;
		end
		if (unit_done) begin
			tmp_q <= unit_result;
		end
		if (state_q == ST_MUL_P && unit_done) begin
			p_q <= unit_result[PROD_W-1:0];
			// The blend weight may go negative; its magnitude and sign go separately.
			if ({1'b0, blend_strength_q} >= edge_mag_q) begin
				str_mag_q <= MULT_W'({1'b0, blend_strength_q} - edge_mag_q);
				str_neg_q <= 1'b0;
			end else begin
				str_mag_q <= MULT_W'(edge_mag_q - {1'b0, blend_strength_q});
				str_neg_q <= 1'b1;
			end
			wk_q <= MULT_W'(SAMPLE_BITS'(SCALE) - blend_strength_q) + MULT_W'(edge_mag_q);
		end
		if (state_q == ST_DIV_B && unit_done) begin
			blend_q <= unit_result[BLEND_W-1:0];
		end
		if (state_q == ST_DIV_P && unit_done) begin
			final_q <= plain_sat;
		end
		if (state_q == ST_DIV_K && unit_done) begin
			final_q <= hq_sat;
		end
		if (state_q == ST_FIN && can_load) begin
			smoothed_q    <= final_q;
			pixels_used_q <= used_q;
		end
	end

	assign result_valid   = result_valid_q;
	assign smoothed_value = smoothed_q;
	assign pixels_used    = pixels_used_q;

endmodule

`default_nettype wire
